@@ design/wpf_pkg.sv @@
package wpf_pkg;

  localparam int CoordW   = 24;
  localparam int DirW     = 16;
  localparam int RadW     = 23;
  localparam int SpeedW   = 16;
  localparam int SumW     = 50;
  localparam int MagW     = 25;
  localparam int QW       = 15;
  localparam int NumW     = 41;
  localparam int DenW     = 26;
  localparam int IdxOutW  = 7;
  localparam int SqrtIter = 25;
  localparam int DivIter  = 15;

  localparam logic signed [DirW-1:0] OneQ14     = 16'sd16384;
  localparam logic [RadW-1:0]        RadiusRst  = 23'd256;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DirW-1:0]   dir_t;

  typedef struct packed {
    logic            start;
    logic            is_sqrt;
    logic [SumW-1:0] num;
    logic [DenW-1:0] den;
  } iter_req_t;

  typedef struct packed {
    logic            done;
    logic [MagW-1:0] result;
  } iter_rsp_t;

endpackage

@@ design/wpf_cfg_if.sv @@
interface wpf_cfg_if import wpf_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [RadW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/wpf_in_if.sv @@
interface wpf_in_if import wpf_pkg::*; ();
  logic              valid;
  logic              ready;
  op_e               op;
  logic              route_select;
  coord_t            coord_x;
  coord_t            coord_y;
  coord_t            coord_z;
  logic [SpeedW-1:0] speed;
  logic [SpeedW-1:0] time_step;

  modport source (output valid, output op, output route_select, output coord_x,
                  output coord_y, output coord_z, output speed, output time_step,
                  input ready);
  modport sink (input valid, input op, input route_select, input coord_x,
                input coord_y, input coord_z, input speed, input time_step,
                output ready);
endinterface

@@ design/wpf_out_if.sv @@
interface wpf_out_if import wpf_pkg::*; ();
  logic               valid;
  logic               ready;
  coord_t             pos_x;
  coord_t             pos_y;
  coord_t             pos_z;
  dir_t               dir_x;
  dir_t               dir_y;
  dir_t               dir_z;
  logic               carrying;
  logic               leg_one_done;
  logic               leg_two_done;
  logic [IdxOutW-1:0] waypoint_index;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output dir_x, output dir_y, output dir_z, output carrying,
                  output leg_one_done, output leg_two_done, output waypoint_index,
                  input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z,
                input dir_x, input dir_y, input dir_z, input carrying,
                input leg_one_done, input leg_two_done, input waypoint_index,
                output ready);
endinterface

@@ design/two_leg_waypoint_follower.sv @@
// Two-leg waypoint follower. Every input word (load waypoint, start, tick, clear routes) gives
// one result word with position, last unit heading, leg flags and waypoint index. A tick that
// moves runs on one shared 25x32 multiplier and one shift-subtract unit for the 25-step square
// root and three 15-step divisions; a tick with an empty route or a finished index goes
// straight to the result. The block takes no new word until the result is taken.
// arrival_radius may be written at any time the block is idle.
module two_leg_waypoint_follower import wpf_pkg::*; #(
  parameter int MAX_WAYPOINTS = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  wpf_cfg_if.sink    cfg_i,
  wpf_in_if.sink     in_i,
  wpf_out_if.source  out_o
);

  localparam int AW = $clog2(MAX_WAYPOINTS);
  localparam int CW = $clog2(MAX_WAYPOINTS + 1);
  localparam logic [CW-1:0] CntMax = CW'(MAX_WAYPOINTS);
  localparam int WpW = 3 * CoordW;

  typedef enum logic [12:0] {
    S_IDLE = 13'h0001,
    S_SUB  = 13'h0002,
    S_SQ   = 13'h0004,
    S_ACC  = 13'h0008,
    S_SQRT = 13'h0010,
    S_SDT  = 13'h0020,
    S_DSUB = 13'h0040,
    S_DIV  = 13'h0080,
    S_STEP = 13'h0100,
    S_UPD  = 13'h0200,
    S_RR   = 13'h0400,
    S_CMP  = 13'h0800,
    S_RESP = 13'h1000
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   pcnt_q, pcnt_d, dcnt_q, dcnt_d, idx_q, idx_d;
  logic            carry_q, carry_d, l1_q, l1_d, l2_q, l2_d;
  coord_t          pos_q [3];
  coord_t          pos_d [3];
  dir_t            hdg_q [3];
  dir_t            hdg_d [3];
  logic [RadW-1:0] rad_q;
  logic [1:0]      k_q, k_d;
  logic            pass2_q, pass2_d, issued_q, issued_d;

  logic [MagW-1:0]   diff_q, diff_d;
  logic [56:0]       prod_q, prod_d;
  logic [SumW-1:0]   acc_q, acc_d;
  logic [MagW-1:0]   mag_q, mag_d;
  logic [31:0]       sdt_q, sdt_d;
  logic [QW-1:0]     qmag_q, qmag_d;
  logic [SpeedW-1:0] spd_q, spd_d, dt_q, dt_d;

  logic            we, re;
  logic [AW:0]     waddr, raddr;
  logic [WpW-1:0]  wdata, rdata;
  iter_req_t       req;
  iter_rsp_t       rsp;

  logic [CW-1:0]   cnt_act, idx_nxt;
  coord_t          wp_k;
  logic [MagW-1:0] dmag;
  logic [24:0]     ma;
  logic [31:0]     mb;
  logic [47:0]     rnd;
  logic [26:0]     step, psum;
  logic [DirW-1:0] hq;
  logic [CW+IdxOutW-1:0] idx_ext;

  wpf_route_mem #(.AddrW(AW + 1), .DataW(WpW)) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  wpf_iter u_iter (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == S_IDLE);

  always_comb begin
    unique case (k_q)
      2'd0:    wp_k = rdata[3*CoordW-1:2*CoordW];
      2'd1:    wp_k = rdata[2*CoordW-1:CoordW];
      default: wp_k = rdata[CoordW-1:0];
    endcase
    cnt_act = carry_q ? dcnt_q : pcnt_q;
    dmag    = diff_q[MagW-1] ? (~diff_q + 25'd1) : diff_q;
    rnd     = prod_q[47:0] + 48'(1 << 21);
    step    = diff_q[MagW-1] ? (27'd0 - {1'b0, rnd[47:22]}) : {1'b0, rnd[47:22]};
    psum    = {{3{pos_q[k_q][CoordW-1]}}, pos_q[k_q]} + step;
    hq      = {1'b0, rsp.result[QW-1:0]};
    idx_nxt = idx_q + CW'(acc_q <= prod_q[SumW-1:0] && prod_q[56:SumW] == '0
                          || prod_q[56:SumW] != '0);
    idx_ext = {{IdxOutW{1'b0}}, idx_q};
  end

  // shared multiplier operands
  always_comb begin
    unique case (state_q)
      S_SQ:    begin ma = dmag;             mb = 32'(dmag);  end
      S_SDT:   begin ma = 25'(spd_q);       mb = 32'(dt_q);  end
      S_STEP:  begin ma = 25'(qmag_q);      mb = sdt_q;      end
      S_RR:    begin ma = 25'(rad_q);       mb = 32'(rad_q); end
      default: begin ma = '0;               mb = '0;         end
    endcase
    prod_d = 57'(ma) * 57'(mb);
  end

  always_comb begin
    state_d  = state_q;
    pcnt_d   = pcnt_q;
    dcnt_d   = dcnt_q;
    idx_d    = idx_q;
    carry_d  = carry_q;
    l1_d     = l1_q;
    l2_d     = l2_q;
    pos_d    = pos_q;
    hdg_d    = hdg_q;
    k_d      = k_q;
    pass2_d  = pass2_q;
    issued_d = issued_q;
    diff_d   = diff_q;
    acc_d    = acc_q;
    mag_d    = mag_q;
    sdt_d    = sdt_q;
    qmag_d   = qmag_q;
    spd_d    = spd_q;
    dt_d     = dt_q;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = {in_i.route_select,
                in_i.route_select ? dcnt_q[AW-1:0] : pcnt_q[AW-1:0]};
    wdata    = {in_i.coord_x, in_i.coord_y, in_i.coord_z};
    raddr    = {carry_q, idx_q[AW-1:0]};
    req.start   = 1'b0;
    req.is_sqrt = (state_q == S_SQRT);
    req.num     = (state_q == S_SQRT) ? acc_q
                  : SumW'({dmag[CoordW-1:0], 15'd0}) + SumW'(mag_q);
    req.den     = {mag_q, 1'b0};

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          state_d = S_RESP;
          unique case (in_i.op)
            OP_LOAD: begin
              if (in_i.route_select) begin
                if (dcnt_q < CntMax) begin
                  we     = 1'b1;
                  dcnt_d = dcnt_q + CW'(1);
                end
              end else if (pcnt_q < CntMax) begin
                we     = 1'b1;
                pcnt_d = pcnt_q + CW'(1);
              end
            end
            OP_START: begin
              pos_d   = '{in_i.coord_x, in_i.coord_y, in_i.coord_z};
              hdg_d   = '{OneQ14, OneQ14, OneQ14};
              idx_d   = CW'(1);
              carry_d = 1'b0;
              l1_d    = 1'b0;
              l2_d    = 1'b0;
            end
            OP_TICK: begin
              spd_d = in_i.speed;
              dt_d  = in_i.time_step;
              if (pcnt_q == '0 || dcnt_q == '0) begin
                state_d = S_RESP;
              end else if (idx_q >= cnt_act) begin
                // index past the end: finish the leg without moving
                if (!carry_q) begin
                  carry_d = 1'b1;
                  l1_d    = 1'b1;
                  idx_d   = '0;
                end else begin
                  carry_d = 1'b0;
                  l2_d    = 1'b1;
                  pcnt_d  = '0;
                  dcnt_d  = '0;
                end
              end else begin
                re      = 1'b1;
                k_d     = 2'd0;
                pass2_d = 1'b0;
                acc_d   = '0;
                state_d = S_SUB;
              end
            end
            OP_CLEAR: begin
              pcnt_d = '0;
              dcnt_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_SUB: begin
        diff_d  = {wp_k[CoordW-1], wp_k} - {pos_q[k_q][CoordW-1], pos_q[k_q]};
        state_d = S_SQ;
      end
      S_SQ: state_d = S_ACC;
      S_ACC: begin
        acc_d = acc_q + prod_q[SumW-1:0];
        if (k_q == 2'd2) begin
          k_d     = 2'd0;
          state_d = pass2_q ? S_RR : S_SQRT;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = S_SUB;
        end
      end
      S_SQRT: begin
        req.start = !issued_q;
        issued_d  = 1'b1;
        if (rsp.done) begin
          issued_d = 1'b0;
          mag_d    = rsp.result;
          if (rsp.result == '0) begin
            // already on the waypoint: hold position and heading
            pass2_d = 1'b1;
            acc_d   = '0;
            state_d = S_SUB;
          end else begin
            state_d = S_SDT;
          end
        end
      end
      S_SDT: state_d = S_DSUB;
      S_DSUB: begin
        if (k_q == 2'd0) begin
          sdt_d = prod_q[31:0];
        end
        diff_d  = {wp_k[CoordW-1], wp_k} - {pos_q[k_q][CoordW-1], pos_q[k_q]};
        state_d = S_DIV;
      end
      S_DIV: begin
        req.start = !issued_q;
        issued_d  = 1'b1;
        if (rsp.done) begin
          issued_d   = 1'b0;
          qmag_d     = rsp.result[QW-1:0];
          hdg_d[k_q] = diff_q[MagW-1] ? (16'd0 - hq) : hq;
          state_d    = S_STEP;
        end
      end
      S_STEP: state_d = S_UPD;
      S_UPD: begin
        if ($signed(psum) > $signed(27'sd8388607)) begin
          pos_d[k_q] = 24'sh7FFFFF;
        end else if ($signed(psum) < $signed(-27'sd8388608)) begin
          pos_d[k_q] = 24'sh800000;
        end else begin
          pos_d[k_q] = psum[CoordW-1:0];
        end
        if (k_q == 2'd2) begin
          k_d     = 2'd0;
          pass2_d = 1'b1;
          acc_d   = '0;
          state_d = S_SUB;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = S_DSUB;
        end
      end
      S_RR: state_d = S_CMP;
      S_CMP: begin
        idx_d = idx_nxt;
        if (idx_nxt >= cnt_act) begin
          if (!carry_q) begin
            carry_d = 1'b1;
            l1_d    = 1'b1;
            idx_d   = '0;
          end else begin
            carry_d = 1'b0;
            l2_d    = 1'b1;
            pcnt_d  = '0;
            dcnt_d  = '0;
          end
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pcnt_q   <= '0;
      dcnt_q   <= '0;
      idx_q    <= CW'(1);
      carry_q  <= 1'b0;
      l1_q     <= 1'b0;
      l2_q     <= 1'b0;
      pos_q    <= '{default: '0};
      hdg_q    <= '{default: OneQ14};
      rad_q    <= RadiusRst;
      k_q      <= '0;
      pass2_q  <= 1'b0;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pcnt_q   <= pcnt_d;
      dcnt_q   <= dcnt_d;
      idx_q    <= idx_d;
      carry_q  <= carry_d;
      l1_q     <= l1_d;
      l2_q     <= l2_d;
      pos_q    <= pos_d;
      hdg_q    <= hdg_d;
      k_q      <= k_d;
      pass2_q  <= pass2_d;
      issued_q <= issued_d;
      if (cfg_i.valid) begin
        rad_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    mag_q  <= mag_d;
    sdt_q  <= sdt_d;
    qmag_q <= qmag_d;
    spd_q  <= spd_d;
    dt_q   <= dt_d;
  end

  assign out_o.valid          = (state_q == S_RESP);
  assign out_o.pos_x          = pos_q[0];
  assign out_o.pos_y          = pos_q[1];
  assign out_o.pos_z          = pos_q[2];
  assign out_o.dir_x          = hdg_q[0];
  assign out_o.dir_y          = hdg_q[1];
  assign out_o.dir_z          = hdg_q[2];
  assign out_o.carrying       = carry_q;
  assign out_o.leg_one_done   = l1_q;
  assign out_o.leg_two_done   = l2_q;
  assign out_o.waypoint_index = idx_ext[IdxOutW-1:0];

`ifndef SYNTHESIS
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= CntMax && pcnt_q <= CntMax && dcnt_q <= CntMax)
    else $error("index or count beyond route depth");

  a_iter_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> (state_q == S_SQRT || state_q == S_DIV))
    else $error("iteration unit finished outside a wait state");

  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !out_o.valid)
    else $error("input taken while a result is pending");

  a_resp_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready) |=> (state_q == S_IDLE))
    else $error("sequencer did not return to idle");
`endif

endmodule

@@ design/wpf_route_mem.sv @@
module wpf_route_mem #(
  parameter int AddrW = 7,
  parameter int DataW = 72
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [2**AddrW];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/wpf_iter.sv @@
module wpf_iter import wpf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  iter_req_t req_i,
  output iter_rsp_t rsp_o
);

  localparam int SqrtTop = 2 * (MagW - 1);

  logic            busy_q, done_q, mode_q;
  logic [4:0]      cnt_q;
  logic [SumW-1:0] v_q, res_q, pwr_q;
  logic [DenW-1:0] rem_q, den_q;
  logic [QW-1:0]   num_q, quo_q;

  logic [SumW-1:0] ta, tb;
  logic [SumW:0]   sub;
  logic            ge;
  logic [4:0]      last;

  // one subtractor serves both the root and the divide step
  always_comb begin
    ta   = mode_q ? v_q : SumW'({rem_q, num_q[QW-1]});
    tb   = mode_q ? (res_q + pwr_q) : SumW'(den_q);
    sub  = {1'b0, ta} - {1'b0, tb};
    ge   = ~sub[SumW];
    last = mode_q ? 5'(SqrtIter - 1) : 5'(DivIter - 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      mode_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      mode_q <= req_i.is_sqrt;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == last) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      v_q   <= req_i.num;
      res_q <= '0;
      pwr_q <= SumW'(1) << SqrtTop;
      rem_q <= req_i.num[NumW-1:QW];
      num_q <= req_i.num[QW-1:0];
      den_q <= req_i.den;
      quo_q <= '0;
    end else if (busy_q) begin
      if (mode_q) begin
        if (ge) begin
          v_q   <= sub[SumW-1:0];
          res_q <= (res_q >> 1) + pwr_q;
        end else begin
          res_q <= res_q >> 1;
        end
        pwr_q <= pwr_q >> 2;
      end else begin
        rem_q <= ge ? sub[DenW-1:0] : ta[DenW-1:0];
        num_q <= num_q << 1;
        quo_q <= {quo_q[QW-2:0], ge};
      end
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = mode_q ? res_q[MagW-1:0] : MagW'(quo_q);

endmodule
